@@ src/cst_pkg.sv @@
// Shared types, constants and a lookup function for the character stream tokenizer.
package cst_pkg;

  // Fixed field widths of the item and result ports.
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned KIND_W = 5;
  localparam int unsigned ERR_W  = 3;
  localparam int unsigned POS_W  = 16;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_MAX_LINE      = 65536;
  localparam int unsigned DEF_KEYWORD_CHARS = 6;

  // Queue depths and their index widths.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned OUT_DEPTH   = 4;
  localparam int unsigned OUT_IDX_W   = $clog2(OUT_DEPTH);

  // Token kinds.
  localparam logic [KIND_W-1:0] KIND_END      = 5'd0;
  localparam logic [KIND_W-1:0] KIND_PLUS     = 5'd2;
  localparam logic [KIND_W-1:0] KIND_MINUS    = 5'd3;
  localparam logic [KIND_W-1:0] KIND_STAR     = 5'd4;
  localparam logic [KIND_W-1:0] KIND_SLASH    = 5'd5;
  localparam logic [KIND_W-1:0] KIND_LPAREN   = 5'd6;
  localparam logic [KIND_W-1:0] KIND_RPAREN   = 5'd7;
  localparam logic [KIND_W-1:0] KIND_EQUAL    = 5'd8;
  localparam logic [KIND_W-1:0] KIND_COLON    = 5'd9;
  localparam logic [KIND_W-1:0] KIND_UNDER    = 5'd10;
  localparam logic [KIND_W-1:0] KIND_COMMA    = 5'd11;
  localparam logic [KIND_W-1:0] KIND_DOT      = 5'd12;
  localparam logic [KIND_W-1:0] KIND_STRING   = 5'd13;
  localparam logic [KIND_W-1:0] KIND_COMMENT  = 5'd14;
  localparam logic [KIND_W-1:0] KIND_INDEXER  = 5'd15;
  localparam logic [KIND_W-1:0] KIND_INT      = 5'd16;
  localparam logic [KIND_W-1:0] KIND_KEYWORD0 = 5'd17;
  localparam logic [KIND_W-1:0] KIND_IDENT    = 5'd26;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE        = 3'd0;
  localparam logic [ERR_W-1:0] ERR_OPEN_STRING = 3'd1;
  localparam logic [ERR_W-1:0] ERR_BAD_COMMENT = 3'd2;
  localparam logic [ERR_W-1:0] ERR_OPEN_INDEX  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_UNKNOWN     = 3'd4;

  // Keyword table, packed with the last character in the low byte.
  localparam int unsigned NUM_KEYWORDS = 9;
  localparam int unsigned KW_BITS      = 48;
  localparam logic [KW_BITS-1:0] KEYWORD_TEXT [NUM_KEYWORDS] = '{
    48'h0000_0000_6966,   // if
    48'h0000_656C_7365,   // else
    48'h0000_006C_6F67,   // log
    48'h636F_6E63_6174,   // concat
    48'h0000_636F_7079,   // copy
    48'h0000_6573_696E,   // esin
    48'h0000_6563_6F73,   // ecos
    48'h0000_6574_616E,   // etan
    48'h0000_0000_5049    // PI
  };

  // Character classes assigned by the front end.
  typedef enum logic [3:0] {
    CLS_NUL,
    CLS_SPACE,
    CLS_OP,
    CLS_QUOTE,
    CLS_DOLLAR,
    CLS_LBRACK,
    CLS_RBRACK,
    CLS_DIGIT,
    CLS_ALPHA,
    CLS_OTHER
  } char_class_e;

  // One classified character as it travels from the front end to the scanner.
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    char_class_e       cls;
    logic [KIND_W-1:0] op_kind;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  pos_next;
  } front_item_t;

  // One result as it waits in the output buffer.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ERR_W-1:0]  err;
    logic [POS_W-1:0]  start;
    logic [POS_W-1:0]  length;
    logic              last;
  } result_t;

  // Token kind of a single-character operator; only meaningful for operator codes.
  function automatic logic [KIND_W-1:0] op_kind_of(input logic [CHAR_W-1:0] c);
    logic [KIND_W-1:0] k;
    k = KIND_END;
    case (c)
      8'h2B: k = KIND_PLUS;
      8'h2D: k = KIND_MINUS;
      8'h2A: k = KIND_STAR;
      8'h2F: k = KIND_SLASH;
      8'h28: k = KIND_LPAREN;
      8'h29: k = KIND_RPAREN;
      8'h3D: k = KIND_EQUAL;
      8'h3A: k = KIND_COLON;
      8'h5F: k = KIND_UNDER;
      8'h2C: k = KIND_COMMA;
      8'h2E: k = KIND_DOT;
      default: k = KIND_END;
    endcase
    return k;
  endfunction

endpackage

@@ src/cst_front.sv @@
// Front end: accepts characters, classifies them and tracks the line position.
module cst_front #(
  parameter int unsigned MAX_LINE = cst_pkg::DEF_MAX_LINE
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [cst_pkg::CHAR_W-1:0]        char_code_i,
  input  logic                              q_full_i,
  output logic                              push_o,
  output cst_pkg::front_item_t              item_o
);
  import cst_pkg::*;

  localparam int unsigned LIMIT_INT = ((MAX_LINE - 1) < 65535) ? (MAX_LINE - 1) : 65535;
  localparam logic [POS_W-1:0] POS_LIMIT = LIMIT_INT[POS_W-1:0];

  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] pos_sat_next;
  char_class_e      cls;

  // Accept whenever the queue to the scanner has room.
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Classify the incoming character.
  always_comb begin
    cls = CLS_OTHER;
    if (char_code_i == 8'h00) begin
      cls = CLS_NUL;
    end else if (char_code_i == 8'h20 || (char_code_i >= 8'h09 && char_code_i <= 8'h0D)) begin
      cls = CLS_SPACE;
    end else if (op_kind_of(char_code_i) != KIND_END) begin
      cls = CLS_OP;
    end else if (char_code_i == 8'h22) begin
      cls = CLS_QUOTE;
    end else if (char_code_i == 8'h24) begin
      cls = CLS_DOLLAR;
    end else if (char_code_i == 8'h5B) begin
      cls = CLS_LBRACK;
    end else if (char_code_i == 8'h5D) begin
      cls = CLS_RBRACK;
    end else if (char_code_i >= 8'h30 && char_code_i <= 8'h39) begin
      cls = CLS_DIGIT;
    end else if ((char_code_i >= 8'h61 && char_code_i <= 8'h7A) ||
                 (char_code_i >= 8'h41 && char_code_i <= 8'h5A)) begin
      cls = CLS_ALPHA;
    end
  end

  // The position saturates at the line limit.
  assign pos_sat_next = (pos_q < POS_LIMIT) ? pos_q + 16'd1 : POS_LIMIT;

  always_comb begin
    item_o.char_code = char_code_i;
    item_o.cls       = cls;
    item_o.op_kind   = op_kind_of(char_code_i);
    item_o.pos       = pos_q;
    item_o.pos_next  = pos_sat_next;
  end

  // End of line returns the position to zero.
  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      pos_d = (cls == CLS_NUL) ? '0 : pos_sat_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

@@ src/cst_queue.sv @@
// Short queue that decouples the front end from the scanner.
module cst_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  cst_pkg::front_item_t item_i,
  output logic                 full_o,
  output logic                 valid_o,
  output cst_pkg::front_item_t item_o,
  input  logic                 pop_i
);
  import cst_pkg::*;

  front_item_t              slot_q [QUEUE_DEPTH];
  logic [QUEUE_IDX_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QUEUE_IDX_W:0]     cnt_q;

  assign full_o  = (cnt_q == (QUEUE_IDX_W+1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (QUEUE_IDX_W+1)'(push_i) - (QUEUE_IDX_W+1)'(pop_i);
    end
  end

endmodule

@@ src/cst_back.sv @@
// Scanner back end: token state machine and the output result buffer.
module cst_back #(
  parameter int unsigned KEYWORD_CHARS = cst_pkg::DEF_KEYWORD_CHARS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  cst_pkg::front_item_t        item_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output cst_pkg::result_t            result_o
);
  import cst_pkg::*;

  localparam int unsigned PB = KEYWORD_CHARS * 8;

  // Scan modes.
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_STRING = 3'd1;
  localparam logic [2:0] MODE_DOLLAR = 3'd2;
  localparam logic [2:0] MODE_INDEX  = 3'd3;
  localparam logic [2:0] MODE_INT    = 3'd4;
  localparam logic [2:0] MODE_WORD   = 3'd5;

  logic [2:0]       mode_q, mode_d;
  logic [POS_W-1:0] begin_q, begin_d;
  logic [PB-1:0]    prefix_q, prefix_d;
  logic             overlong_q, overlong_d;
  logic [1:0]       dcount_q, dcount_d;
  logic             hold_q, hold_d;

  logic [POS_W-1:0]  span;
  logic [KIND_W-1:0] word_kind;
  logic              close_vld, close_err;
  result_t           close_res;
  logic              a_vld, b_vld;
  result_t           a_res, b_res;
  logic              word_char;

  // Output buffer.
  result_t                rb_q [OUT_DEPTH];
  logic [OUT_IDX_W-1:0]   rb_wr_q, rb_rd_q;
  logic [OUT_IDX_W:0]     rb_cnt_q;
  logic                   rb_pop;
  logic [1:0]             n_wr;
  result_t                w0_res, w1_res;

  // Take an item only when the buffer can absorb two results.
  assign pop_o = valid_i && (rb_cnt_q <= (OUT_IDX_W+1)'(OUT_DEPTH - 2));

  assign span      = item_i.pos - begin_q;
  assign word_char = (item_i.cls == CLS_ALPHA) || (item_i.cls == CLS_DIGIT);

  // Keyword lookup on the held word.
  always_comb begin
    word_kind = KIND_IDENT;
    for (int i = 0; i < NUM_KEYWORDS; i++) begin
      if (!overlong_q && prefix_q == PB'(KEYWORD_TEXT[i])) begin
        word_kind = KIND_KEYWORD0 + KIND_W'(i);
      end
    end
  end

  // Result that closes the pending token at the current position.
  always_comb begin
    close_vld = 1'b0;
    close_err = 1'b0;
    close_res = '{kind: KIND_END, err: ERR_NONE, start: begin_q, length: span, last: 1'b0};
    case (mode_q)
      MODE_STRING: begin
        close_vld     = 1'b1;
        close_err     = 1'b1;
        close_res.err = ERR_OPEN_STRING;
      end
      MODE_INDEX: begin
        close_vld     = 1'b1;
        close_err     = 1'b1;
        close_res.err = ERR_OPEN_INDEX;
      end
      MODE_DOLLAR: begin
        close_vld = 1'b1;
        if (dcount_q == 2'd3) begin
          close_res.kind = KIND_COMMENT;
        end else begin
          close_err     = 1'b1;
          close_res.err = ERR_BAD_COMMENT;
        end
      end
      MODE_INT: begin
        close_vld      = 1'b1;
        close_res.kind = KIND_INT;
      end
      MODE_WORD: begin
        close_vld      = 1'b1;
        close_res.kind = word_kind;
      end
      default: begin
        close_vld = 1'b0;
      end
    endcase
  end

  // Scanner step: slot a carries a closing result, slot b a result for the character.
  always_comb begin
    logic do_close;
    logic do_start;
    mode_d     = mode_q;
    begin_d    = begin_q;
    prefix_d   = prefix_q;
    overlong_d = overlong_q;
    dcount_d   = dcount_q;
    hold_d     = hold_q;
    a_vld      = 1'b0;
    b_vld      = 1'b0;
    a_res      = close_res;
    b_res      = '{kind: KIND_END, err: ERR_NONE, start: item_i.pos,
                   length: 16'd1, last: 1'b1};
    do_close   = 1'b0;
    do_start   = 1'b0;

    if (pop_o) begin
      if (item_i.cls == CLS_NUL) begin
        // End of line: close what is open, emit the end token, clear all state.
        a_vld        = close_vld && !hold_q;
        b_vld        = 1'b1;
        b_res.length = '0;
        mode_d       = MODE_IDLE;
        begin_d      = '0;
        prefix_d     = '0;
        overlong_d   = 1'b0;
        dcount_d     = '0;
        hold_d       = 1'b0;
      end else if (!hold_q) begin
        case (mode_q)
          MODE_STRING: begin
            if (item_i.cls == CLS_QUOTE) begin
              a_vld      = 1'b1;
              a_res.kind = KIND_STRING;
              a_res.err  = ERR_NONE;
              mode_d     = MODE_IDLE;
            end
          end
          MODE_INDEX: begin
            if (item_i.cls == CLS_RBRACK) begin
              a_vld        = 1'b1;
              a_res.kind   = KIND_INDEXER;
              a_res.err    = ERR_NONE;
              a_res.length = span + 16'd1;
              mode_d       = MODE_IDLE;
            end else if (item_i.cls != CLS_DIGIT) begin
              a_vld  = 1'b1;
              hold_d = 1'b1;
              mode_d = MODE_IDLE;
            end
          end
          MODE_DOLLAR: begin
            if (item_i.cls == CLS_DOLLAR) begin
              dcount_d = (dcount_q == 2'd1) ? 2'd2 : ((dcount_q == 2'd2) ? 2'd3 : 2'd0);
            end else begin
              do_close = 1'b1;
            end
          end
          MODE_INT: begin
            do_close = (item_i.cls != CLS_DIGIT);
          end
          MODE_WORD: begin
            if (word_char) begin
              if (prefix_q[PB-1 -: 8] != 8'h00) begin
                overlong_d = 1'b1;
              end
              prefix_d = {prefix_q[PB-9:0], item_i.char_code};
            end else begin
              do_close = 1'b1;
            end
          end
          default: begin
            do_start = 1'b1;
          end
        endcase

        // Close the pending token; an error stops handling of this character.
        if (do_close) begin
          a_vld  = close_vld;
          mode_d = MODE_IDLE;
          if (close_err) begin
            hold_d = 1'b1;
          end else begin
            do_start = 1'b1;
          end
        end

        // Handle the character as the start of a new token.
        if (do_start) begin
          case (item_i.cls)
            CLS_SPACE: begin
              b_vld = 1'b0;
            end
            CLS_OP: begin
              b_vld      = 1'b1;
              b_res.kind = item_i.op_kind;
            end
            CLS_QUOTE: begin
              mode_d  = MODE_STRING;
              begin_d = item_i.pos_next;
            end
            CLS_DOLLAR: begin
              mode_d   = MODE_DOLLAR;
              begin_d  = item_i.pos;
              dcount_d = 2'd1;
            end
            CLS_LBRACK: begin
              mode_d  = MODE_INDEX;
              begin_d = item_i.pos;
            end
            CLS_DIGIT: begin
              mode_d  = MODE_INT;
              begin_d = item_i.pos;
            end
            CLS_ALPHA: begin
              mode_d     = MODE_WORD;
              begin_d    = item_i.pos;
              prefix_d   = PB'(item_i.char_code);
              overlong_d = 1'b0;
            end
            default: begin
              b_vld     = 1'b1;
              b_res.err = ERR_UNKNOWN;
              hold_d    = 1'b1;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      begin_q    <= '0;
      prefix_q   <= '0;
      overlong_q <= 1'b0;
      dcount_q   <= '0;
      hold_q     <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      begin_q    <= begin_d;
      prefix_q   <= prefix_d;
      overlong_q <= overlong_d;
      dcount_q   <= dcount_d;
      hold_q     <= hold_d;
    end
  end

  // Pack the results of this step in order and mark the final one.
  always_comb begin
    w0_res      = a_vld ? a_res : b_res;
    w0_res.last = !(a_vld && b_vld);
    w1_res      = b_res;
    w1_res.last = 1'b1;
    n_wr        = {1'b0, a_vld} + {1'b0, b_vld};
  end

  assign out_valid_o = (rb_cnt_q != '0);
  assign result_o    = rb_q[rb_rd_q];
  assign rb_pop      = out_valid_o && !out_stall_i;

  // Buffer storage: up to two writes per cycle.
  always_ff @(posedge clk_i) begin
    if (n_wr != 2'd0) begin
      rb_q[rb_wr_q] <= w0_res;
    end
    if (n_wr == 2'd2) begin
      rb_q[rb_wr_q + 1'b1] <= w1_res;
    end
  end

  // Buffer pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rb_wr_q  <= '0;
      rb_rd_q  <= '0;
      rb_cnt_q <= '0;
    end else begin
      rb_wr_q  <= rb_wr_q + OUT_IDX_W'(n_wr);
      if (rb_pop) begin
        rb_rd_q <= rb_rd_q + 1'b1;
      end
      rb_cnt_q <= rb_cnt_q + (OUT_IDX_W+1)'(n_wr) - (OUT_IDX_W+1)'(rb_pop);
    end
  end

endmodule

@@ src/char_stream_tokenizer_unit.sv @@
// Top level of the character stream tokenizer: front end, queue and scanner.
//
// Usage: the input channel takes one line character per transaction on
// char_code_i; byte 0 ends the line. The output channel delivers tokens as
// kind, error code, start offset and length, with last_of_run_o set on the
// final result that a character causes. A character yields zero, one or two
// results. Both channels transfer when valid is high and stall is low.
// Throughput: one character per cycle while in_stall_o is low. A character
// that gives two results has both held in the four-entry result buffer.
// An accepted character reaches the output through the registered
// classification queue and then the registered result buffer. The scanner
// takes a character only when the buffer has room for two results, so a
// stalled receiver fills the buffer, then the four-entry queue, and then
// in_stall_o rises. Reset clears the position, the scanner state and both
// queues; no transaction is pending after it.
module char_stream_tokenizer_unit #(
  parameter int unsigned MAX_LINE      = cst_pkg::DEF_MAX_LINE,
  parameter int unsigned KEYWORD_CHARS = cst_pkg::DEF_KEYWORD_CHARS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [cst_pkg::CHAR_W-1:0]  char_code_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [cst_pkg::KIND_W-1:0]  token_kind_o,
  output logic [cst_pkg::ERR_W-1:0]   error_code_o,
  output logic [cst_pkg::POS_W-1:0]   token_start_o,
  output logic [cst_pkg::POS_W-1:0]   token_length_o,
  output logic                        last_of_run_o
);
  import cst_pkg::*;

  logic        push, q_full, q_valid, q_pop;
  front_item_t front_item, queue_item;
  result_t     result;

  // Classification and position tracking.
  cst_front #(
    .MAX_LINE (MAX_LINE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .item_o      (front_item)
  );

  // Queue between front end and scanner.
  cst_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (queue_item),
    .pop_i   (q_pop)
  );

  // Token scanner and result buffer.
  cst_back #(
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (queue_item),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign token_kind_o   = result.kind;
  assign error_code_o   = result.err;
  assign token_start_o  = result.start;
  assign token_length_o = result.length;
  assign last_of_run_o  = result.last;

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the character stream tokenizer: table-driven and random lines.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cst_pkg::*;

  // Scanner geometry taken from the default parameters of the block.
  localparam int unsigned POS_LIMIT_INT = (DEF_MAX_LINE - 1 < 65535) ? DEF_MAX_LINE - 1 : 65535;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(POS_LIMIT_INT);
  localparam int unsigned TAIL_BITS = DEF_KEYWORD_CHARS * 8;

  // Run length, stall and timeout settings.
  localparam int unsigned RANDOM_ITEMS = 1650;
  localparam int unsigned LONG_TEXT    = 48;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned MAX_REPORTS  = 10;

  // Characters with a role of their own in the token grammar.
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;

  // Operator characters in the order of their token kinds, starting at KIND_PLUS.
  localparam logic [CHAR_W-1:0] OP_CHARS [11] = '{
    "+", "-", "*", "/", "(", ")", "=", ":", "_", ",", "."
  };
  localparam logic [CHAR_W-1:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

  // Scanner modes of the predictor.
  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_STRING,
    SCAN_DOLLAR,
    SCAN_INDEX,
    SCAN_INT,
    SCAN_WORD
  } scan_e;

  // One row of the directed table; has_want marks a result typed in by hand.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              has_want;
    logic [KIND_W-1:0] kind;
    logic [ERR_W-1:0]  err;
    logic [POS_W-1:0]  start;
    logic [POS_W-1:0]  len;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 26;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // End of line straight after reset, then an operator and an unknown byte.
    '{CH_NUL,    1'b1, KIND_END,  ERR_NONE,    16'd0, 16'd0},
    '{"+",       1'b1, KIND_PLUS, ERR_NONE,    16'd0, 16'd1},
    '{8'hFF,     1'b1, KIND_END,  ERR_UNKNOWN, 16'd1, 16'd1},
    // Dropped after the error; the end token still carries the offset.
    '{"a",       1'b0, KIND_END,  ERR_NONE,    16'd0, 16'd0},
    '{CH_NUL,    1'b1, KIND_END,  ERR_NONE,    16'd3, 16'd0},
    // Keyword closed by an operator, an empty string, a comment, an indexer.
    '{"P",       1'b0, KIND_END,  ERR_NONE,    16'd0, 16'd0},
    '{"I",       1'b0, KIND_END,  ERR_NONE,    16'd0, 16'd0},
    '{"+",       1'b0, KIND_END,  ERR_NONE,    16'd0, 16'd0},
    '{CH_QUOTE,  1'b0, KIND_END,  ERR_NONE,    16'd0, 16'd0},
    '{CH_QUOTE,  1'b0, KIND_END,  ERR_NONE,    16'd0, 16'd0},
    '{CH_DOLLAR, 1'b0, KIND_END,  ERR_NONE,    16'd0, 16'd0},
    '{CH_DOLLAR, 1'b0, KIND_END,  ERR_NONE,    16'd0, 16'd0},
    '{CH_DOLLAR, 1'b0, KIND_END,  ERR_NONE,    16'd0, 16'd0},
    '{CH_NL,     1'b0, KIND_END,  ERR_NONE,    16'd0, 16'd0},
    '{CH_LBRACK, 1'b0, KIND_END,  ERR_NONE,    16'd0, 16'd0},
    '{"7",       1'b0, KIND_END,  ERR_NONE,    16'd0, 16'd0},
    '{CH_RBRACK, 1'b0, KIND_END,  ERR_NONE,    16'd0, 16'd0},
    // Indexer broken by a letter.
    '{CH_LBRACK, 1'b0, KIND_END,  ERR_NONE,    16'd0, 16'd0},
    '{"x",       1'b0, KIND_END,  ERR_NONE,    16'd0, 16'd0},
    '{CH_NUL,    1'b0, KIND_END,  ERR_NONE,    16'd0, 16'd0},
    // Dollar run of two at the end of the line.
    '{CH_DOLLAR, 1'b0, KIND_END,  ERR_NONE,    16'd0, 16'd0},
    '{CH_DOLLAR, 1'b0, KIND_END,  ERR_NONE,    16'd0, 16'd0},
    '{CH_NUL,    1'b0, KIND_END,  ERR_NONE,    16'd0, 16'd0},
    // String left open at the end of the line.
    '{CH_QUOTE,  1'b0, KIND_END,  ERR_NONE,    16'd0, 16'd0},
    '{"z",       1'b0, KIND_END,  ERR_NONE,    16'd0, 16'd0},
    '{CH_NUL,    1'b0, KIND_END,  ERR_NONE,    16'd0, 16'd0}
  };

  string kw_names [9] = '{"if", "else", "log", "concat", "copy", "esin", "ecos", "etan", "PI"};
  string other_text = "!#%&';<>?@\\^`{|}~";

  // Block ports.
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [CHAR_W-1:0] char_code_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [KIND_W-1:0] token_kind_o;
  logic [ERR_W-1:0]  error_code_o;
  logic [POS_W-1:0]  token_start_o;
  logic [POS_W-1:0]  token_length_o;
  logic              last_of_run_o;

  // Predictor state.
  scan_e                scan;
  logic [POS_W-1:0]     line_pos;
  logic [POS_W-1:0]     tok_begin;
  logic [TAIL_BITS-1:0] word_tail;
  bit                   word_long;
  logic [1:0]           dollar_run;
  bit                   in_error;
  result_t              step_tok [2];
  int unsigned          step_cnt;

  // Tokens still owed by the block, oldest first.
  result_t tok_q [$];
  logic [CHAR_W-1:0] line_chars [$];

  int unsigned fail_count  = 0;
  int unsigned live_items  = 0;
  int unsigned idle_cycles = 0;
  int unsigned calm_in     = 0;
  int unsigned calm_out    = 0;
  int unsigned stall_left  = 0;
  int unsigned hold_left   = 0;
  bit          hold_taken  = 1'b0;
  logic        hold_go     = 1'b0;

  char_stream_tokenizer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_code_i   (char_code_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .token_kind_o  (token_kind_o),
    .error_code_o  (error_code_o),
    .token_start_o (token_start_o),
    .token_length_o(token_length_o),
    .last_of_run_o (last_of_run_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_blank(logic [CHAR_W-1:0] c);
    return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit is_digit(logic [CHAR_W-1:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [CHAR_W-1:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void clear_scanner();
    scan       = SCAN_IDLE;
    line_pos   = '0;
    tok_begin  = '0;
    word_tail  = '0;
    word_long  = 1'b0;
    dollar_run = '0;
    in_error   = 1'b0;
  endfunction

  function automatic void put_token(logic [KIND_W-1:0] kind, logic [ERR_W-1:0] err,
                                    logic [POS_W-1:0] start, logic [POS_W-1:0] len);
    result_t r;
    r.kind   = kind;
    r.err    = err;
    r.start  = start;
    r.length = len;
    r.last   = 1'b0;
    if (step_cnt < 2) step_tok[step_cnt] = r;
    step_cnt++;
  endfunction

  function automatic void flag_error(logic [ERR_W-1:0] err, logic [POS_W-1:0] start,
                                     logic [POS_W-1:0] len);
    put_token(KIND_END, err, start, len);
    in_error = 1'b1;
    scan     = SCAN_IDLE;
  endfunction

  // A word is a keyword only if it is short enough and matches exactly.
  function automatic logic [KIND_W-1:0] word_kind();
    logic [KIND_W-1:0] k;
    k = KIND_IDENT;
    if (!word_long) begin
      for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
        if (KEYWORD_TEXT[i] == KW_BITS'(word_tail)) k = KIND_KEYWORD0 + KIND_W'(i);
      end
    end
    return k;
  endfunction

  // Closes the token in progress at offset p; returns 1 when that is an error.
  function automatic bit close_token(logic [POS_W-1:0] p);
    scan_e            m;
    logic [POS_W-1:0] n;
    m    = scan;
    n    = p - tok_begin;
    scan = SCAN_IDLE;
    case (m)
      SCAN_STRING: begin
        flag_error(ERR_OPEN_STRING, tok_begin, n);
        return 1'b1;
      end
      SCAN_INDEX: begin
        flag_error(ERR_OPEN_INDEX, tok_begin, n);
        return 1'b1;
      end
      SCAN_DOLLAR: begin
        if (dollar_run == 2'd3) begin
          put_token(KIND_COMMENT, ERR_NONE, tok_begin, n);
          return 1'b0;
        end
        flag_error(ERR_BAD_COMMENT, tok_begin, n);
        return 1'b1;
      end
      SCAN_INT:  put_token(KIND_INT, ERR_NONE, tok_begin, n);
      SCAN_WORD: put_token(word_kind(), ERR_NONE, tok_begin, n);
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Handles a character that arrives between tokens.
  function automatic void open_token(logic [CHAR_W-1:0] c, logic [POS_W-1:0] p);
    if (is_blank(c)) return;
    for (int i = 0; i < 11; i++) begin
      if (c == OP_CHARS[i]) begin
        put_token(KIND_PLUS + KIND_W'(i), ERR_NONE, p, 16'd1);
        return;
      end
    end
    if (c == CH_QUOTE) begin
      scan      = SCAN_STRING;
      tok_begin = (p < POS_MAX) ? p + 16'd1 : POS_MAX;
    end else if (c == CH_DOLLAR) begin
      scan       = SCAN_DOLLAR;
      tok_begin  = p;
      dollar_run = 2'd1;
    end else if (c == CH_LBRACK) begin
      scan      = SCAN_INDEX;
      tok_begin = p;
    end else if (is_digit(c)) begin
      scan      = SCAN_INT;
      tok_begin = p;
    end else if (is_alpha(c)) begin
      scan      = SCAN_WORD;
      tok_begin = p;
      word_tail = TAIL_BITS'(c);
      word_long = 1'b0;
    end else begin
      flag_error(ERR_UNKNOWN, p, 16'd1);
    end
  endfunction

  function automatic void scan_char(logic [CHAR_W-1:0] c, logic [POS_W-1:0] p);
    if (in_error) return;
    case (scan)
      SCAN_STRING: begin
        if (c == CH_QUOTE) begin
          put_token(KIND_STRING, ERR_NONE, tok_begin, p - tok_begin);
          scan = SCAN_IDLE;
        end
        return;
      end
      SCAN_INDEX: begin
        if (is_digit(c)) return;
        if (c == CH_RBRACK) begin
          put_token(KIND_INDEXER, ERR_NONE, tok_begin, p - tok_begin + 16'd1);
          scan = SCAN_IDLE;
        end else begin
          flag_error(ERR_OPEN_INDEX, tok_begin, p - tok_begin);
        end
        return;
      end
      SCAN_DOLLAR: begin
        // The run count goes 1, 2, 3 and then sticks at 0 for any longer run.
        if (c == CH_DOLLAR) begin
          dollar_run = (dollar_run == 2'd1) ? 2'd2 : ((dollar_run == 2'd2) ? 2'd3 : 2'd0);
          return;
        end
      end
      SCAN_INT: begin
        if (is_digit(c)) return;
      end
      SCAN_WORD: begin
        if (is_alpha(c) || is_digit(c)) begin
          if (word_tail[TAIL_BITS-1 -: 8] != 8'd0) word_long = 1'b1;
          word_tail = {word_tail[TAIL_BITS-9:0], c};
          return;
        end
      end
      default: ;
    endcase
    if (close_token(p)) return;
    open_token(c, p);
  endfunction

  // Works out the tokens one character causes into step_tok.
  function automatic void tokenize_char(logic [CHAR_W-1:0] c);
    logic [POS_W-1:0] p;
    p        = line_pos;
    step_cnt = 0;
    if (c == CH_NUL) begin
      if (!in_error) void'(close_token(p));
      put_token(KIND_END, ERR_NONE, p, '0);
      clear_scanner();
    end else begin
      scan_char(c, p);
      if (line_pos < POS_MAX) line_pos++;
    end
  endfunction

  function automatic void queue_tokens();
    result_t r;
    for (int i = 0; i < int'(step_cnt); i++) begin
      r      = step_tok[i];
      r.last = (i == int'(step_cnt) - 1);
      tok_q.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------

  function automatic string show(result_t r);
    return $sformatf("kind=%0d err=%0d start=%0d len=%0d last=%0d",
                     r.kind, r.err, r.start, r.length, r.last);
  endfunction

  function automatic void check_token();
    result_t got;
    result_t want;
    string   diff;
    got.kind   = token_kind_o;
    got.err    = error_code_o;
    got.start  = token_start_o;
    got.length = token_length_o;
    got.last   = last_of_run_o;
    if (tok_q.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("[%0t] token with none expected: %s", $time, show(got));
      return;
    end
    want = tok_q.pop_front();
    diff = "";
    if (got.kind != want.kind) diff = {diff, " kind"};
    if (got.err != want.err) diff = {diff, " err"};
    if (got.start != want.start) diff = {diff, " start"};
    if (got.length != want.length) diff = {diff, " len"};
    if (got.last != want.last) diff = {diff, " last"};
    if (diff != "") begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("[%0t] token mismatch in%s: expected %s, got %s", $time, diff, show(want),
                 show(got));
    end
  endfunction

  // Mostly short stalls, a few long ones, and calm stretches with none.
  function automatic bit pick_stall();
    int unsigned r;
    if (stall_left > 0) begin
      stall_left--;
      return 1'b1;
    end
    if (calm_out > 0) begin
      calm_out--;
      return 1'b0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 1'b0;
    if (r < 88) begin
      stall_left = $urandom_range(0, 2);
      return 1'b1;
    end
    if (r < 93) begin
      stall_left = $urandom_range(15, 60);
      return 1'b1;
    end
    calm_out = $urandom_range(20, 100);
    return 1'b0;
  endfunction

  // Sample each output transaction, then choose the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_token();
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= pick_stall();
      end
    end
  end

  // Watchdog on cycles without any transaction on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Sender gaps; none while the receiver is held off so that the block fills up.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (hold_left > 0) return 0;
    if (calm_in > 0) begin
      calm_in--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(10, 40);
    calm_in = $urandom_range(20, 80);
    return 0;
  endfunction

  // Offers one character and returns at the edge where its transaction completes.
  task automatic send_char(input logic [CHAR_W-1:0] c, input bit no_gaps);
    int unsigned gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    live_items++;
  endtask

  task automatic feed(input logic [CHAR_W-1:0] c, input bit no_gaps);
    send_char(c, no_gaps);
    tokenize_char(c);
    queue_tokens();
  endtask

  // Stops offering and waits until every owed token has been delivered.
  task automatic wait_for_tokens();
    in_valid_i <= 1'b0;
    while (tok_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [CHAR_W-1:0] rand_letter();
    int unsigned r;
    r = $urandom_range(0, 51);
    return (r < 26) ? "a" + CHAR_W'(r) : "A" + CHAR_W'(r - 26);
  endfunction

  function automatic logic [CHAR_W-1:0] rand_digit();
    return "0" + CHAR_W'($urandom_range(0, 9));
  endfunction

  function automatic logic [CHAR_W-1:0] rand_alnum();
    return ($urandom_range(0, 61) < 10) ? rand_digit() : rand_letter();
  endfunction

  // Any byte that a string may hold.
  function automatic logic [CHAR_W-1:0] rand_string_char();
    logic [CHAR_W-1:0] c;
    c = CHAR_W'($urandom_range(1, 255));
    if (c == CH_QUOTE) c = "q";
    return c;
  endfunction

  // A character outside every token class.
  function automatic logic [CHAR_W-1:0] rand_unknown();
    case ($urandom_range(0, 3))
      0: return CHAR_W'($urandom_range(128, 255));
      1: return CHAR_W'($urandom_range(1, 8));
      2: return ($urandom_range(0, 4) == 0) ? 8'h7F : CHAR_W'($urandom_range(14, 31));
      default: return other_text[$urandom_range(0, other_text.len() - 1)];
    endcase
  endfunction

  // Appends one token's worth of characters, mostly well formed.
  function automatic void add_fragment();
    int unsigned sel;
    int unsigned n;
    string       kw;
    sel = $urandom_range(0, 99);
    if (sel < 14) begin
      line_chars.push_back(OP_CHARS[$urandom_range(0, 10)]);
    end else if (sel < 20) begin
      line_chars.push_back(BLANKS[$urandom_range(0, 5)]);
    end else if (sel < 30) begin
      line_chars.push_back(CH_QUOTE);
      n = $urandom_range(0, 6);
      repeat (n) line_chars.push_back(rand_string_char());
      line_chars.push_back(CH_QUOTE);
    end else if (sel < 40) begin
      n = ($urandom_range(0, 3) != 0) ? 3 : $urandom_range(1, 6);
      repeat (n) line_chars.push_back(CH_DOLLAR);
    end else if (sel < 50) begin
      line_chars.push_back(CH_LBRACK);
      n = $urandom_range(0, 4);
      repeat (n) line_chars.push_back(rand_digit());
      line_chars.push_back(CH_RBRACK);
    end else if (sel < 60) begin
      n = $urandom_range(1, 5);
      repeat (n) line_chars.push_back(rand_digit());
    end else if (sel < 76) begin
      // Keywords, now and then with a letter before or a character after.
      kw = kw_names[$urandom_range(0, 8)];
      if ($urandom_range(0, 7) == 0) line_chars.push_back(rand_letter());
      for (int i = 0; i < kw.len(); i++) line_chars.push_back(kw[i]);
      if ($urandom_range(0, 5) == 0) line_chars.push_back(rand_alnum());
    end else if (sel < 90) begin
      line_chars.push_back(rand_letter());
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 5);
      repeat (n) line_chars.push_back(rand_alnum());
    end else if (sel < 94) begin
      // Indexer broken by a character that is neither a digit nor a bracket.
      line_chars.push_back(CH_LBRACK);
      n = $urandom_range(0, 2);
      repeat (n) line_chars.push_back(rand_digit());
      line_chars.push_back(($urandom_range(0, 1) != 0) ? rand_letter()
                                                       : OP_CHARS[$urandom_range(0, 10)]);
    end else if (sel < 97) begin
      line_chars.push_back(rand_unknown());
    end else begin
      line_chars.push_back(CHAR_W'($urandom_range(1, 255)));
    end
  endfunction

  task automatic send_random_line();
    int unsigned frags;
    line_chars.delete();
    frags = $urandom_range(1, 8);
    repeat (frags) begin
      add_fragment();
      if ($urandom_range(0, 9) < 6) line_chars.push_back(CH_SPACE);
    end
    // Now and then a string or an indexer is left open at the end of the line.
    case ($urandom_range(0, 19))
      0: begin
        line_chars.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 3)) line_chars.push_back(rand_string_char());
      end
      1: begin
        line_chars.push_back(CH_LBRACK);
        repeat ($urandom_range(0, 3)) line_chars.push_back(rand_digit());
      end
      default: ;
    endcase
    line_chars.push_back(CH_NUL);
    foreach (line_chars[i]) feed(line_chars[i], 1'b0);
  endtask

  // Main sequence: reset, directed table, back-to-back long string, random lines.
  initial begin : stimulus
    result_t want;
    bit      paused;
    paused = 1'b0;
    clear_scanner();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; hand-typed rows replace the predicted token.
    for (int i = 0; i < int'(DIR_ROWS); i++) begin
      send_char(DIRECTED[i].ch, 1'b0);
      tokenize_char(DIRECTED[i].ch);
      if (DIRECTED[i].has_want) begin
        want.kind   = DIRECTED[i].kind;
        want.err    = DIRECTED[i].err;
        want.start  = DIRECTED[i].start;
        want.length = DIRECTED[i].len;
        want.last   = 1'b1;
        tok_q.push_back(want);
      end else begin
        queue_tokens();
      end
    end
    wait_for_tokens();

    // A long string sent back to back, then one word of a letter and a digit.
    feed(CH_QUOTE, 1'b1);
    repeat (LONG_TEXT) feed(rand_string_char(), 1'b1);
    feed(CH_QUOTE, 1'b1);
    feed("x", 1'b1);
    feed("9", 1'b1);
    feed(CH_NUL, 1'b1);
    wait_for_tokens();

    // Random lines, with one long receiver hold-off and one full drain.
    live_items = 0;
    hold_go <= 1'b1;
    while (live_items < RANDOM_ITEMS) begin
      send_random_line();
      if (!paused && live_items > RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        wait_for_tokens();
      end
    end
    wait_for_tokens();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
